/* hw/rtl/stt_pkg.sv */
// Shared types and constants of the segment transit time averager.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package stt_pkg;

	// Field widths
	localparam int SENSOR_W    = 7;
	localparam int TICK_W      = 32;
	localparam int MEAN_W      = 16;
	localparam int COUNT_W     = 16;
	localparam int NUM_SENSORS_DEF = 80;

	// Stream words: fields packed from bit 0 up, padded to whole bytes
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// Divider operands: mean*count + delta needs one bit above 32
	localparam int SUM_W     = MEAN_W + COUNT_W + 1;
	localparam int DIVISOR_W = COUNT_W + 1;
	localparam int DIV_STEPS = MEAN_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [MEAN_W-1:0]  DELTA_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_EMIT
	} state_t;

	// One table entry
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [MEAN_W-1:0]  mean;
	} tbl_entry_t;

	// Divider request and response
	typedef struct packed {
		logic                 start;
		logic [SUM_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [MEAN_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* hw/rtl/segment_transit_time_averager.sv */
// Segment transit time averager: each sensor trip word (sensor, tick) yields one result
// word. A trip from a sensor other than the previous one folds the elapsed ticks, saturated
// to 16 bits, into the previous sensor's mean as (mean*count+delta)/(count+1) and reports
// the new mean and saturating count with tuser set; first, repeated or out-of-range trips
// report zeros with tuser clear. An updating word goes through one table read, one
// multiply and the 16-step divider before its result is emitted; a word that updates
// nothing skips all three. The block is not ready while a word is in work or while its
// result waits for a full output register. Tables read as zero right after reset; no
// clearing pass is needed.
`timescale 1ns / 1ps

module segment_transit_time_averager #(
	parameter int NUM_SENSORS = stt_pkg::NUM_SENSORS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [6:0] sensor_id, [38:7] tick_now, [39] zero
	input  logic [stt_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [6:0] segment, [22:7] mean_ticks, [38:23] sample_count, [39] zero
	output logic [stt_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] updated
	output logic                          m_tuser
);
	import stt_pkg::*;

	localparam int AW = $clog2(NUM_SENSORS);

	state_t              state_q, state_d;
	logic [SENSOR_W-1:0] sid_q;
	logic [TICK_W-1:0]   tick_q;
	logic                have_last_q;
	logic [SENSOR_W-1:0] last_sensor_q;
	logic [TICK_W-1:0]   last_tick_q;
	logic                upd_q;
	logic [MEAN_W-1:0]   delta_q;
	logic [SUM_W-2:0]    prod_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic                out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic                out_user_q;

	logic                in_range;
	logic                skip;
	logic [TICK_W-1:0]   diff;
	logic                out_free;
	logic                accept;
	logic                rd_en;
	logic                div_start;
	logic                emit;
	logic                wr_en;
	logic [COUNT_W-1:0]  cnt_next;
	tbl_entry_t          rd_data;
	tbl_entry_t          wr_data;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// Classify the held word
	assign in_range = (9'(sid_q) < 9'(NUM_SENSORS));
	assign skip     = !in_range || !have_last_q || (sid_q == last_sensor_q);
	assign diff     = tick_q - last_tick_q;
	assign out_free = !out_valid_q || m_tready;
	assign cnt_next = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_CHECK;
			ST_CHECK: state_d = skip ? ST_EMIT : ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_DIV;
			ST_DIV:   if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_CHECK: rd_en = !skip;
			ST_SUM:   div_start = 1'b1;
			ST_EMIT:  emit = out_free;
			default:  ;
		endcase
	end

	assign accept        = s_tvalid && s_tready;
	assign wr_en         = emit && upd_q;
	assign div_req       = '{
		start:    div_start,
		dividend: {1'b0, prod_q} + SUM_W'(delta_q),
		divisor:  {1'b0, cnt_q} + 1'b1
	};
	assign wr_data.mean  = div_rsp.quotient;
	assign wr_data.count = cnt_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			sid_q  <= s_tdata[SENSOR_W-1:0];
			tick_q <= s_tdata[SENSOR_W +: TICK_W];
		end
	end

	// Track last sensor and last counted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_last_q   <= 1'b0;
			last_sensor_q <= '0;
			last_tick_q   <= '0;
		end else if (state_q == ST_CHECK && in_range && !have_last_q) begin
			have_last_q   <= 1'b1;
			last_sensor_q <= sid_q;
		end else if (wr_en) begin
			last_sensor_q <= sid_q;
			last_tick_q   <= tick_q;
		end
	end

	// Operand registers for the mean update
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			upd_q   <= !skip;
			delta_q <= (|diff[TICK_W-1:MEAN_W]) ? DELTA_MAX : diff[MEAN_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= rd_data.mean * rd_data.count;
			cnt_q  <= rd_data.count;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_user_q <= upd_q;
			out_data_q <= upd_q ? {1'b0, cnt_next, div_rsp.quotient, last_sensor_q} : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	stt_table #(
		.NUM_SENSORS (NUM_SENSORS),
		.AW          (AW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (AW'(last_sensor_q)),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (AW'(last_sensor_q)),
		.wr_data (wr_data)
	);

	stt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	a_zero_on_skip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("non-updating result carries data");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[SENSOR_W+MEAN_W +: COUNT_W] != '0)
		else $error("updating result with zero count");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

endmodule

/* hw/rtl/stt_div.sv */
// Restoring divider, one quotient bit per cycle, for the mean update.
// Depends on stt_pkg. The quotient is known to fit MEAN_W bits.
`timescale 1ns / 1ps

module stt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  stt_pkg::div_req_t req,
	output stt_pkg::div_rsp_t rsp
);
	import stt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [MEAN_W-1:0]    quo_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [DIVISOR_W:0]   trial;
	logic                 fits;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[MEAN_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	// Control: step counter, busy and done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: the upper half of the dividend is already below the divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[SUM_W-1 -: DIVISOR_W];
			quo_q <= req.dividend[MEAN_W-1:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : DIVISOR_W'(trial);
			quo_q <= {quo_q[MEAN_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q && !done_q)
		else $error("divider did not start");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start && cnt_q == DIV_CNT_W'(DIV_STEPS - 1) |=> done_q && !busy_q)
		else $error("divider did not finish after its last step");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");

endmodule

/* hw/rtl/stt_table.sv */
// Per-sensor table of mean and sample count, one read and one write port.
// Depends on stt_pkg. Valid bits make every entry read as zero after reset.
`timescale 1ns / 1ps

module stt_table #(
	parameter int NUM_SENSORS = stt_pkg::NUM_SENSORS_DEF,
	parameter int AW          = $clog2(NUM_SENSORS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output stt_pkg::tbl_entry_t rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  stt_pkg::tbl_entry_t wr_data
);
	import stt_pkg::*;

	tbl_entry_t             mem_q [NUM_SENSORS];
	logic [NUM_SENSORS-1:0] valid_q;
	tbl_entry_t             rd_q;

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read; an entry never written reads as zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	assign rd_data = rd_q;

endmodule
